// ----- design/fba_pkg.sv -----
`default_nettype none
package fba_pkg;

  // Default sizing
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int BLOCK_W  = 4;
  localparam int AMOUNT_W = 16;
  localparam int POLICY_W = 2;
  localparam int BLOCKS_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

  // Fit policy codes (anything else behaves as first fit)
  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  // Register reset values
  localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fba_state_t;

endpackage
`default_nettype wire

// ----- design/fba_if.sv -----
`default_nettype none
// Request channel
interface fba_in_if;
  import fba_pkg::*;
  logic                valid;
  logic                ready;
  logic                func;
  logic [BLOCK_W-1:0]  block_index;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, output func, output block_index, output amount,
                  input ready);
  modport sink (input valid, input func, input block_index, input amount,
                output ready);
endinterface

// Result channel
interface fba_out_if;
  import fba_pkg::*;
  logic                valid;
  logic                ready;
  logic                granted;
  logic [BLOCK_W-1:0]  chosen_block;
  logic [AMOUNT_W-1:0] left_in_block;

  modport source (output valid, output granted, output chosen_block,
                  output left_in_block, input ready);
  modport sink (input valid, input granted, input chosen_block,
                input left_in_block, output ready);
endinterface
`default_nettype wire

// ----- design/fit_policy_block_allocator_top.sv -----
// Block allocator with first, best and worst fit. Remaining capacities of up to
// NUM_BLOCKS blocks sit in one single-port-read memory with a registered read.
// A load item writes one capacity and its result is ready the cycle after the
// transfer. An allocate item reads blocks 0 .. n-1 (n = min(blocks_in_use,
// NUM_BLOCKS)) one entry per cycle through the memory read port, then writes
// the chosen block back if one fits, and posts the result. One item is
// worked on at a time; a new item is taken once the result register is empty
// or is being emptied in that cycle. Capacities hold no reset value: every
// block scanned by an allocate must have been loaded first.
// fit_policy and blocks_in_use may be written only while no item is in flight.
`default_nettype none
module fit_policy_block_allocator_top #(
  parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = fba_pkg::SIZE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fba_pkg::CFG_DATA_W-1:0] cfg_wdata,
  fba_in_if.sink                             in_ch,
  fba_out_if.source                          out_ch
);
  import fba_pkg::*;

  localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam logic [CNT_W-1:0] NUM_BLOCKS_C = CNT_W'(NUM_BLOCKS);

  fba_state_t state_r, state_nxt;

  logic [POLICY_W-1:0]   policy_r;
  logic [BLOCKS_W-1:0]   blocks_r;
  logic [SIZE_WIDTH-1:0] amt_r, amt_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      issue_r, issue_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [SIZE_WIDTH-1:0] rd_data_r;
  logic                  found_r, found_nxt;
  logic [ADDR_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_WIDTH-1:0] best_r, best_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_granted_r, out_granted_nxt;
  logic [BLOCK_W-1:0]    out_block_r, out_block_nxt;
  logic [AMOUNT_W-1:0]   out_left_r, out_left_nxt;

  // Capacity memory
  logic [SIZE_WIDTH-1:0] space_mem [NUM_BLOCKS];
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [SIZE_WIDTH-1:0] mem_wdata;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;

  logic                  out_free;
  logic [SIZE_WIDTH-1:0] in_amt;
  logic                  load_ok;
  logic [CNT_W-1:0]      n_lim;
  logic                  fits;
  logic                  take;
  logic [SIZE_WIDTH-1:0] left_val;

  assign in_amt   = SIZE_WIDTH'(in_ch.amount);
  assign load_ok  = int'(in_ch.block_index) < NUM_BLOCKS;
  assign n_lim    = (int'(blocks_r) > NUM_BLOCKS) ? NUM_BLOCKS_C : CNT_W'(blocks_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign left_val = best_r - amt_r;

  // Scan compare on the entry read last cycle
  assign fits = rd_data_r >= amt_r;
  assign take = fits && (!found_r ||
                         (policy_r == POLICY_BEST  && rd_data_r < best_r) ||
                         (policy_r == POLICY_WORST && rd_data_r > best_r));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_FIRST;
      blocks_r <= BLOCKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT_POLICY:    policy_r <= cfg_wdata[POLICY_W-1:0];
        CFG_BLOCKS_IN_USE: blocks_r <= cfg_wdata[BLOCKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state and datapath control
  always_comb begin
    state_nxt       = state_r;
    amt_nxt         = amt_r;
    n_nxt           = n_r;
    issue_nxt       = issue_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = issue_r;
    found_nxt       = found_r;
    pick_nxt        = pick_r;
    best_nxt        = best_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_granted_nxt = out_granted_r;
    out_block_nxt   = out_block_r;
    out_left_nxt    = out_left_r;
    in_ch.ready     = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = out_free;
        if (in_ch.valid && out_free) begin
          if (in_ch.func == FUNC_LOAD) begin
            out_valid_nxt = 1'b1;
            if (load_ok) begin
              mem_we          = 1'b1;
              mem_waddr       = ADDR_W'(in_ch.block_index);
              mem_wdata       = in_amt;
              out_granted_nxt = 1'b1;
              out_block_nxt   = in_ch.block_index;
              out_left_nxt    = AMOUNT_W'(in_amt);
            end else begin
              out_granted_nxt = 1'b0;
              out_block_nxt   = '0;
              out_left_nxt    = '0;
            end
          end else begin
            amt_nxt   = in_amt;
            n_nxt     = n_lim;
            issue_nxt = '0;
            found_nxt = 1'b0;
            pick_nxt  = '0;
            best_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle
        if (issue_r < n_r) begin
          rd_en      = 1'b1;
          rd_addr    = issue_r[ADDR_W-1:0];
          rd_vld_nxt = 1'b1;
          issue_nxt  = issue_r + CNT_W'(1);
        end
        // Evaluate the returned entry
        if (rd_vld_r) begin
          if (take) begin
            found_nxt = 1'b1;
            pick_nxt  = rd_idx_r[ADDR_W-1:0];
            best_nxt  = rd_data_r;
          end
          if (rd_idx_r == n_r - CNT_W'(1)) begin
            state_nxt = ST_DONE;
          end
        end
        if (n_r == '0) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // Write back and post the result
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (found_r) begin
            mem_we          = 1'b1;
            mem_waddr       = pick_r;
            mem_wdata       = left_val;
            out_granted_nxt = 1'b1;
            out_block_nxt   = BLOCK_W'(pick_r);
            out_left_nxt    = AMOUNT_W'(left_val);
          end else begin
            out_granted_nxt = 1'b0;
            out_block_nxt   = '0;
            out_left_nxt    = '0;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    amt_r         <= amt_nxt;
    n_r           <= n_nxt;
    issue_r       <= issue_nxt;
    rd_idx_r      <= rd_idx_nxt;
    found_r       <= found_nxt;
    pick_r        <= pick_nxt;
    best_r        <= best_nxt;
    out_granted_r <= out_granted_nxt;
    out_block_r   <= out_block_nxt;
    out_left_r    <= out_left_nxt;
  end

  // Capacity memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      space_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= space_mem[rd_addr];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.granted       = out_granted_r;
  assign out_ch.chosen_block  = out_block_r;
  assign out_ch.left_in_block = out_left_r;

endmodule
`default_nettype wire

// ----- design/fba_checker.sv -----
`default_nettype none
module fba_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_func,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_granted,
  input wire logic [fba_pkg::BLOCK_W-1:0]  out_chosen_block,
  input wire logic [fba_pkg::AMOUNT_W-1:0] out_left_in_block
);
  import fba_pkg::*;

  logic in_xfer;
  logic out_xfer;
  logic [1:0] pending_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_r <= pending_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  // One item in flight at most, and no result without an item
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 2'd1)
    else $error("more than one item in flight");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r == 2'd1)
    else $error("result without an accepted item");

  // A load answers in the next cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_func == FUNC_LOAD |=> out_valid)
    else $error("load result late");

  // A refusal carries zero fields
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_chosen_block == '0 && out_left_in_block == '0)
    else $error("refused result with nonzero fields");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted) &&
      $stable(out_chosen_block) && $stable(out_left_in_block))
    else $error("stalled result changed");

endmodule

bind fit_policy_block_allocator_top fba_checker u_fba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_func           (in_ch.func),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_granted       (out_ch.granted),
  .out_chosen_block  (out_ch.chosen_block),
  .out_left_in_block (out_ch.left_in_block)
);
`default_nettype wire
